// ===== hdl/lstp_pkg.sv =====
// Shared types, constants and register codes for the link stats tick policy unit.
// No dependencies; every other file in the project imports this package.
package lstp_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_IS_OUTGOING = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HAS_VIDEO   = 8'd1;

    // restart cadence
    localparam int RESTART_PERIOD = 7;
    localparam int PHASE_W = (RESTART_PERIOD > 1) ? $clog2(RESTART_PERIOD) : 1;

    // bar thresholds
    localparam logic [15:0] RTT_HIGH_MS = 16'd400;
    localparam logic [15:0] RTT_MID_MS  = 16'd150;
    localparam logic [19:0] LOSS_UNIT   = 20'd65536;
    localparam logic [2:0]  BARS_FULL   = 3'd4;

    // cap limits; floor(bwe*4/5) exceeds the max once bwe reaches CAP_SAT_BWE
    localparam logic [10:0] CAP_MIN_KBPS = 11'd24;
    localparam logic [10:0] CAP_MAX_KBPS = 11'd1500;
    localparam logic [19:0] CAP_SAT_BWE  = 20'd1877;
    // divide by five below saturation: (x * 13108) >> 16, exact for x < 7508
    localparam logic [14:0] DIV5_MUL   = 15'd13108;
    localparam int          DIV5_SHIFT = 16;
    // cap * 1024 reaches the audio ceiling of 32768 bps from 32 kbps up
    localparam logic [10:0] AUDIO_SAT_KBPS = 11'd32;
    localparam logic [15:0] AUDIO_MAX_BPS  = 16'd32768;

    // one-shot tick points
    localparam logic [3:0] TICK_APM    = 4'd10;
    localparam logic [3:0] TICK_CONFIG = 4'd12;

    localparam int IN_W  = 56;
    localparam int OUT_W = 72;

    typedef struct packed {
        logic        connected;
        logic [19:0] bwe_kbps;
        logic        bwe_valid;
        logic [15:0] loss_q16;
        logic        loss_valid;
        logic [15:0] rtt_ms;
        logic        rtt_valid;
    } tick_in_t;

    typedef struct packed {
        logic        config_apply;
        logic        apm_apply;
        logic [15:0] restart_count;
        logic        transport_restart;
        logic [20:0] video_cap_bps;
        logic        video_cap_valid;
        logic [15:0] audio_cap_bps;
        logic [10:0] cap_kbps;
        logic        cap_update;
        logic [2:0]  bars;
    } tick_out_t;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic                 data;
    } cfg_wr_t;

endpackage

// ===== hdl/lstp_policy.sv =====
// Per-tick policy datapath and its state: bars, sender cap, restarts, one-shots.
// Depends on lstp_pkg; instantiated by link_stats_tick_policy_unit.
module lstp_policy
    import lstp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_wr_t   cfg_wr,
    input  logic      step,
    input  tick_in_t  tick,
    output tick_out_t result
);

    logic               is_outgoing_reg;
    logic               has_video_reg;
    logic [10:0]        last_cap_reg,      last_cap_next;
    logic [PHASE_W-1:0] restart_phase_reg, restart_phase_next;
    logic [3:0]         tick_count_reg,    tick_count_next;
    logic [15:0]        restarts_done_reg, restarts_done_next;
    logic               apm_done_reg,      apm_done_next;
    logic               config_done_reg,   config_done_next;

    logic [2:0]  rtt_pen;
    logic [2:0]  loss_pen;
    logic [2:0]  pen_sum;
    logic [19:0] loss_x10;
    logic [21:0] loss_x50;
    logic [12:0] bwe_x4;
    logic [27:0] div_prod;
    logic [10:0] cap_quot;
    logic [10:0] cap;
    logic [10:0] cap_diff;
    logic [14:0] diff_x10;
    logic        cap_issue;
    logic [PHASE_W:0] phase_inc;
    logic        restart;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_outgoing_reg <= 1'b0;
            has_video_reg   <= 1'b0;
        end
        else if (cfg_wr.valid)
        begin
            unique case (cfg_wr.index)
                REG_IS_OUTGOING: is_outgoing_reg <= cfg_wr.data;
                REG_HAS_VIDEO:   has_video_reg   <= cfg_wr.data;
                default:         ;
            endcase
        end
    end

    // bars
    always_comb
    begin
        loss_x10 = 20'(tick.loss_q16) * 20'd10;
        loss_x50 = 22'(tick.loss_q16) * 22'd50;
        rtt_pen  = 3'd0;
        loss_pen = 3'd0;
        if (tick.rtt_valid)
        begin
            if (tick.rtt_ms > RTT_HIGH_MS)
                rtt_pen = 3'd2;
            else if (tick.rtt_ms > RTT_MID_MS)
                rtt_pen = 3'd1;
        end
        if (tick.loss_valid)
        begin
            if (loss_x10 > LOSS_UNIT)
                loss_pen = 3'd2;
            else if (loss_x50 > 22'(LOSS_UNIT))
                loss_pen = 3'd1;
        end
        pen_sum = rtt_pen + loss_pen;
    end

    // sender cap
    always_comb
    begin
        bwe_x4   = {tick.bwe_kbps[10:0], 2'b00};
        div_prod = 28'(bwe_x4) * 28'(DIV5_MUL);
        cap_quot = div_prod[DIV5_SHIFT +: 11];
        if (tick.bwe_kbps >= CAP_SAT_BWE)
            cap = CAP_MAX_KBPS;
        else if (cap_quot < CAP_MIN_KBPS)
            cap = CAP_MIN_KBPS;
        else
            cap = cap_quot;
        cap_diff  = (cap > last_cap_reg) ? cap - last_cap_reg : last_cap_reg - cap;
        diff_x10  = 15'(cap_diff) * 15'd10;
        cap_issue = tick.bwe_valid && (last_cap_reg == 11'd0 || diff_x10 > 15'(last_cap_reg));
    end

    // counters and one-shots
    always_comb
    begin
        phase_inc = {1'b0, restart_phase_reg} + 1'b1;
        if (phase_inc >= (PHASE_W+1)'(RESTART_PERIOD))
            restart_phase_next = '0;
        else
            restart_phase_next = phase_inc[PHASE_W-1:0];
        tick_count_next = (tick_count_reg < TICK_CONFIG) ? tick_count_reg + 4'd1 : tick_count_reg;
        restart = is_outgoing_reg && tick.connected && (restart_phase_next == '0);
        restarts_done_next = restart ? restarts_done_reg + 16'd1 : restarts_done_reg;
        apm_done_next      = apm_done_reg || (tick_count_next >= TICK_APM);
        config_done_next   = config_done_reg || (tick_count_next >= TICK_CONFIG);
        last_cap_next      = cap_issue ? cap : last_cap_reg;
    end

    always_comb
    begin
        result = '0;
        result.bars              = (pen_sum >= BARS_FULL) ? 3'd0 : BARS_FULL - pen_sum;
        result.cap_update        = cap_issue;
        result.transport_restart = restart;
        result.restart_count     = restarts_done_next;
        result.apm_apply         = !apm_done_reg && apm_done_next;
        result.config_apply      = !config_done_reg && config_done_next;
        if (cap_issue)
        begin
            result.cap_kbps      = cap;
            result.audio_cap_bps = (cap >= AUDIO_SAT_KBPS) ? AUDIO_MAX_BPS
                                                           : {cap[5:0], 10'd0};
            if (has_video_reg)
            begin
                result.video_cap_valid = 1'b1;
                result.video_cap_bps   = {cap, 10'd0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cap_reg      <= '0;
            restart_phase_reg <= '0;
            tick_count_reg    <= '0;
            restarts_done_reg <= '0;
            apm_done_reg      <= 1'b0;
            config_done_reg   <= 1'b0;
        end
        else if (step)
        begin
            last_cap_reg      <= last_cap_next;
            restart_phase_reg <= restart_phase_next;
            tick_count_reg    <= tick_count_next;
            restarts_done_reg <= restarts_done_next;
            apm_done_reg      <= apm_done_next;
            config_done_reg   <= config_done_next;
        end
    end

endmodule

// ===== hdl/link_stats_tick_policy_unit.sv =====
// Top level of the link stats tick policy unit: stream ports, input and result registers.
// Depends on lstp_pkg and lstp_policy.

// One stats tick in, one result beat out. A tick sits in the input register, where
// lstp_policy evaluates it in a single pass and updates its state, and then waits in
// the result register until taken. Throughput is one tick per cycle while the result
// side keeps tready high. A stalled result holds the result register, and the input
// register too once it holds a tick. Configuration writes complete in the cycle they
// are presented and should be issued only while no tick is in flight.
module link_stats_tick_policy_unit
    import lstp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // tick input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata: rtt_valid, rtt_ms[16], loss_valid, loss_q16[16], bwe_valid,
    //        bwe_kbps[20], connected
    input  logic [IN_W-1:0]      s_tdata,
    // result output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata: bars[3], cap_update, cap_kbps[11], audio_cap_bps[16], video_cap_valid,
    //        video_cap_bps[21], transport_restart, restart_count[16], apm_apply,
    //        config_apply
    output logic [OUT_W-1:0]     m_tdata,
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data
);

    logic      in_valid_reg;
    tick_in_t  in_reg;
    logic      out_valid_reg;
    tick_out_t out_reg;
    logic      out_free;
    logic      advance;
    cfg_wr_t   cfg_wr;
    tick_out_t result;

    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    lstp_policy u_policy (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .step   (advance),
        .tick   (in_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload: load on a beat, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_reg <= tick_in_t'(s_tdata);
        if (advance)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_reg);

`ifndef SYNTH
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a stalled result beat");

    a_bars_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] <= 3'd4))
        else $error("bars out of range");

    a_no_cap_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[3]) |-> (m_tdata[52:4] == '0))
        else $error("cap fields nonzero without a cap update");

    a_video_needs_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[31]) |-> (m_tdata[3] && m_tdata[52:42] == m_tdata[14:4]))
        else $error("video cap inconsistent with issued cap");

    a_result_follows_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_free) |=> m_tvalid)
        else $error("evaluated tick produced no result beat");
`endif

endmodule

// ===== dv/link_stats_tick_policy_unit_tb.sv =====
// Self-checking testbench for link_stats_tick_policy_unit: directed and random stats ticks,
// an in-bench policy predictor, and result checks under randomized handshake stalls.
// Depends on lstp_pkg and the link_stats_tick_policy_unit RTL.
module link_stats_tick_policy_unit_tb;
    import lstp_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_TICKS   = 175;
    localparam int MAX_PRINTED   = 100;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic                 cfg_data = 1'b0;

    link_stats_tick_policy_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tick_in_t  ticks_to_send[$];
    tick_out_t tick_results_due[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;
    int stall_cycles  = 0;
    int bwe_anchor    = 125;

    // predictor state and register copies
    int   last_cap_kbps = 0;
    int   restart_phase = 0;
    int   tick_cnt      = 0;
    logic [15:0] restart_total = '0;
    logic apm_fired   = 1'b0;
    logic cfg_fired   = 1'b0;
    logic outgoing_en = 1'b0;
    logic video_en    = 1'b0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic report_error(string msg);
        if (error_count < MAX_PRINTED)
            $display("ERROR %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic tick_out_t calc_tick_result(tick_in_t t);
        tick_out_t r;
        int bars_left;
        int loss_num;
        int cap;
        int delta;
        r = '0;
        bars_left = int'(BARS_FULL);
        loss_num = int'(t.loss_q16);
        if (t.rtt_valid)
        begin
            if (t.rtt_ms > RTT_HIGH_MS)
                bars_left -= 2;
            else if (t.rtt_ms > RTT_MID_MS)
                bars_left -= 1;
        end
        if (t.loss_valid)
        begin
            if (loss_num * 10 > LOSS_UNIT)
                bars_left -= 2;
            else if (loss_num * 50 > LOSS_UNIT)
                bars_left -= 1;
        end
        if (bars_left < 0)
            bars_left = 0;
        r.bars = bars_left[2:0];

        if (t.bwe_valid)
        begin
            cap = int'(t.bwe_kbps);
            cap = cap * 4 / 5;
            if (cap < CAP_MIN_KBPS)
                cap = CAP_MIN_KBPS;
            if (cap > CAP_MAX_KBPS)
                cap = CAP_MAX_KBPS;
            delta = (cap > last_cap_kbps) ? cap - last_cap_kbps : last_cap_kbps - cap;
            // reissue only on the first cap or a swing of more than a tenth
            if (last_cap_kbps == 0 || delta * 10 > last_cap_kbps)
            begin
                last_cap_kbps = cap;
                r.cap_update = 1'b1;
                r.cap_kbps = cap[10:0];
                r.audio_cap_bps = (cap * 1024 > AUDIO_MAX_BPS) ? AUDIO_MAX_BPS
                                                               : 16'(cap * 1024);
                if (video_en)
                begin
                    r.video_cap_valid = 1'b1;
                    r.video_cap_bps = 21'(cap * 1024);
                end
            end
        end

        restart_phase = (restart_phase + 1 >= RESTART_PERIOD) ? 0 : restart_phase + 1;
        if (tick_cnt < TICK_CONFIG)
            tick_cnt++;
        if (outgoing_en && t.connected && restart_phase == 0)
        begin
            restart_total++;
            r.transport_restart = 1'b1;
        end
        r.restart_count = restart_total;
        if (!apm_fired && tick_cnt >= TICK_APM)
        begin
            apm_fired = 1'b1;
            r.apm_apply = 1'b1;
        end
        if (!cfg_fired && tick_cnt >= TICK_CONFIG)
        begin
            cfg_fired = 1'b1;
            r.config_apply = 1'b1;
        end
        return r;
    endfunction

    function automatic tick_in_t tick(logic rv, logic [15:0] rtt, logic lv, logic [15:0] loss,
                                      logic bv, logic [19:0] bwe, logic conn);
        tick_in_t t;
        t.rtt_valid  = rv;
        t.rtt_ms     = rtt;
        t.loss_valid = lv;
        t.loss_q16   = loss;
        t.bwe_valid  = bv;
        t.bwe_kbps   = bwe;
        t.connected  = conn;
        return t;
    endfunction

    function automatic tick_in_t make_tick();
        tick_in_t t;
        int pick;
        t.rtt_valid = ($urandom_range(99) < 80);
        case ($urandom_range(2))
            0: t.rtt_ms = 16'($urandom_range(200));
            1: t.rtt_ms = 16'($urandom_range(480, 120));
            default: t.rtt_ms = 16'($urandom_range(16'hFFFF));
        endcase
        t.loss_valid = ($urandom_range(99) < 80);
        case ($urandom_range(2))
            0: t.loss_q16 = 16'($urandom_range(1500));
            1: t.loss_q16 = 16'($urandom_range(7000, 1200));
            default: t.loss_q16 = 16'($urandom_range(16'hFFFF));
        endcase
        t.bwe_valid = ($urandom_range(99) < 85);
        pick = $urandom_range(9);
        // half the time, hover around the recent bandwidth to work the ten percent window
        if (pick < 5)
            t.bwe_kbps = 20'(bwe_anchor * $urandom_range(118, 84) / 100);
        else if (pick == 7)
            t.bwe_kbps = 20'($urandom_range(20'hFFFFF));
        else
        begin
            case (pick)
                5: t.bwe_kbps = 20'($urandom_range(40));
                6: t.bwe_kbps = 20'($urandom_range(1950, 1800));
                default: t.bwe_kbps = 20'($urandom_range(1900, 30));
            endcase
            bwe_anchor = int'(t.bwe_kbps);
        end
        t.connected = ($urandom_range(99) < 85);
        return t;
    endfunction

    task automatic queue_tick(tick_in_t t);
        ticks_to_send = {ticks_to_send, t};
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        while (ticks_to_send.size() != 0 || s_tvalid || tick_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // tick driver and result-side backpressure
    always @(posedge clk)
    begin
        if (!s_tvalid || s_tready)
        begin
            if (ticks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= ticks_to_send.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // predict on every accepted tick, check every result beat
    always @(posedge clk)
    begin : result_check
        tick_out_t got;
        tick_out_t want;
        tick_out_t pred;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_IS_OUTGOING)
                    outgoing_en = cfg_data;
                else if (cfg_index == REG_HAS_VIDEO)
                    video_en = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                pred = calc_tick_result(tick_in_t'(s_tdata));
                tick_results_due = {tick_results_due, pred};
            end
            if (m_tvalid && m_tready)
            begin
                got = tick_out_t'(m_tdata);
                if (tick_results_due.size() == 0)
                    report_error($sformatf("result beat with nothing expected: %h", m_tdata));
                else
                begin
                    want = tick_results_due.pop_front();
                    if (got.bars != want.bars)
                        report_error($sformatf("bars got %0d expected %0d",
                                               got.bars, want.bars));
                    if (got.cap_update != want.cap_update)
                        report_error($sformatf("cap_update got %0d expected %0d",
                                               got.cap_update, want.cap_update));
                    if (got.cap_kbps != want.cap_kbps)
                        report_error($sformatf("cap_kbps got %0d expected %0d",
                                               got.cap_kbps, want.cap_kbps));
                    if (got.audio_cap_bps != want.audio_cap_bps)
                        report_error($sformatf("audio_cap_bps got %0d expected %0d",
                                               got.audio_cap_bps, want.audio_cap_bps));
                    if (got.video_cap_valid != want.video_cap_valid)
                        report_error($sformatf("video_cap_valid got %0d expected %0d",
                                               got.video_cap_valid, want.video_cap_valid));
                    if (got.video_cap_bps != want.video_cap_bps)
                        report_error($sformatf("video_cap_bps got %0d expected %0d",
                                               got.video_cap_bps, want.video_cap_bps));
                    if (got.transport_restart != want.transport_restart)
                        report_error($sformatf("transport_restart got %0d expected %0d",
                                               got.transport_restart,
                                               want.transport_restart));
                    if (got.restart_count != want.restart_count)
                        report_error($sformatf("restart_count got %0d expected %0d",
                                               got.restart_count, want.restart_count));
                    if (got.apm_apply != want.apm_apply)
                        report_error($sformatf("apm_apply got %0d expected %0d",
                                               got.apm_apply, want.apm_apply));
                    if (got.config_apply != want.config_apply)
                        report_error($sformatf("config_apply got %0d expected %0d",
                                               got.config_apply, want.config_apply));
                end
            end
        end
    end

    // end the run if no beat of any kind moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL link_stats_tick_policy_unit");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // both registers on, then writes to unused indexes that must change nothing
        write_reg(REG_IS_OUTGOING, 1'b1);
        write_reg(REG_HAS_VIDEO, 1'b1);
        write_reg(8'd2, 1'b0);
        write_reg(8'd255, 1'b0);
        cfg_valid <= 1'b0;

        send_idle_pct = 38;
        recv_idle_pct = 73;
        // threshold edges for rtt and loss, cap hysteresis edges, clamps, one-shots
        queue_tick(tick(1'b0, 16'd0, 1'b0, 16'd0, 1'b0, 20'd0, 1'b1));
        queue_tick(tick(1'b1, 16'd150, 1'b1, 16'd1310, 1'b1, 20'd125, 1'b1));
        queue_tick(tick(1'b1, 16'd151, 1'b1, 16'd1311, 1'b1, 20'd138, 1'b1));
        queue_tick(tick(1'b1, 16'd400, 1'b1, 16'd6553, 1'b1, 20'd139, 1'b1));
        queue_tick(tick(1'b1, 16'd401, 1'b1, 16'd6554, 1'b1, 20'd125, 1'b1));
        queue_tick(tick(1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 20'd124, 1'b1));
        queue_tick(tick(1'b1, 16'hFFFF, 1'b0, 16'hFFFF, 1'b1, 20'd0, 1'b1));
        queue_tick(tick(1'b0, 16'hFFFF, 1'b1, 16'd0, 1'b0, 20'hFFFFF, 1'b1));
        queue_tick(tick(1'b0, 16'd0, 1'b1, 16'hFFFF, 1'b1, 20'hFFFFF, 1'b1));
        queue_tick(tick(1'b1, 16'd0, 1'b0, 16'd0, 1'b1, 20'd1874, 1'b1));
        queue_tick(tick(1'b1, 16'd0, 1'b0, 16'd0, 1'b1, 20'd39, 1'b1));
        queue_tick(tick(1'b1, 16'd0, 1'b0, 16'd0, 1'b1, 20'd41, 1'b1));
        queue_tick(tick(1'b1, 16'd0, 1'b0, 16'd0, 1'b1, 20'd44, 1'b1));
        queue_tick(tick(1'b1, 16'd200, 1'b1, 16'd3000, 1'b1, 20'd1877, 1'b0));
        queue_tick(tick(1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 20'd1876, 1'b1));
        queue_tick(tick(1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 20'd1689, 1'b1));
        queue_tick(tick(1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 20'd1686, 1'b1));
        queue_tick(tick(1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 20'd30, 1'b1));
        queue_tick(tick(1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 20'd1, 1'b1));
        queue_tick(tick(1'b1, 16'd300, 1'b1, 16'd2000, 1'b0, 20'd0, 1'b1));
        queue_tick(tick(1'b1, 16'd500, 1'b0, 16'd0, 1'b1, 20'h80000, 1'b1));
        queue_tick(tick(1'b0, 16'd0, 1'b0, 16'd0, 1'b1, 20'h7FFFF, 1'b0));
        wait_idle();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            write_reg(REG_IS_OUTGOING, (ph % 2) == 0);
            write_reg(REG_HAS_VIDEO, (ph % 3) != 1);
            cfg_valid <= 1'b0;
            case (ph / 2)
                0:
                begin
                    send_idle_pct = 38;
                    recv_idle_pct = 73;
                end
                1:
                begin
                    send_idle_pct = 73;
                    recv_idle_pct = 38;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_TICKS; n++)
                queue_tick(make_tick());
            wait_idle();
        end

        if (tick_results_due.size() != 0)
            report_error($sformatf("%0d results never arrived", tick_results_due.size()));
        if (error_count == 0)
            $display("PASS link_stats_tick_policy_unit");
        else
            $display("FAIL link_stats_tick_policy_unit");
        $finish;
    end

endmodule
